// ----- hw/rtl/bmp24_pkg.sv -----
// Package for the 24-bit BMP pixel stream decoder.
// Types, codes, header byte positions and the divide-by-three helper.
// No dependencies.
package bmp24_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 24;

  localparam int HEADER_BYTES   = 54;
  localparam int HDR_OFFSET_POS = 10;
  localparam int HDR_WIDTH_POS  = 18;
  localparam int HDR_HEIGHT_POS = 22;
  localparam int HDR_DEPTH_POS  = 28;

  // Position of the last byte of each little-endian header field
  localparam logic [31:0] POS_OFFSET_END = 32'(HDR_OFFSET_POS + 3);
  localparam logic [31:0] POS_WIDTH_END  = 32'(HDR_WIDTH_POS + 3);
  localparam logic [31:0] POS_HEIGHT_END = 32'(HDR_HEIGHT_POS + 3);
  localparam logic [31:0] POS_DEPTH_END  = 32'(HDR_DEPTH_POS + 1);
  localparam logic [31:0] POS_HEADER_END = 32'(HEADER_BYTES - 1);
  localparam logic [31:0] POS_DATA_MIN   = 32'(HEADER_BYTES);

  localparam logic [15:0]       DEPTH_24     = 16'd24;
  localparam logic [BYTE_W-1:0] BW_THRESHOLD = 8'd127;

  // Register word indexes on the config port
  localparam logic REG_PIXEL_MODE = 1'b0;

  typedef enum logic [1:0] {
    MODE_COLOUR = 2'd0,
    MODE_GREY   = 2'd1,
    MODE_BW     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_PIXEL     = 2'd0,
    STATUS_BAD_DEPTH = 2'd1,
    STATUS_BAD_SIZE  = 2'd2
  } status_e;

  // Position inside a pixel triplet, or in the row padding
  typedef enum logic [3:0] {
    PH_BLUE  = 4'b0001,
    PH_GREEN = 4'b0010,
    PH_RED   = 4'b0100,
    PH_PAD   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] file_byte;
    logic              start_of_file;
  } byte_item_t;

  // floor(sum/3) for sum up to 765: reciprocal 683/2048 is exact there
  function automatic logic [BYTE_W-1:0] div3(input logic [9:0] sum);
    logic [20:0] prod;
    prod = {11'd0, sum} * 21'd683;
    return prod[18:11];
  endfunction

endpackage

// ----- hw/rtl/bmp24_byte_if.sv -----
// Input channel of the BMP decoder: one file byte per word.
// Depends on nothing.
interface bmp24_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

// ----- hw/rtl/bmp24_pix_if.sv -----
// Result channel of the BMP decoder: one pixel or error status per word.
// Depends on nothing.
interface bmp24_pix_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  level;
  logic        last_pixel;

  modport source (output valid, output status, output pixel_index, output red,
                  output green, output blue, output level, output last_pixel,
                  input ready);
  modport sink   (input valid, input status, input pixel_index, input red,
                  input green, input blue, input level, input last_pixel,
                  output ready);
endinterface

// ----- hw/rtl/bmp24_cfg_regs.sv -----
// APB-style register file of the BMP decoder: holds pixel_mode.
// Depends on bmp24_pkg.
module bmp24_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  pixel_mode_o
);

  logic [1:0] mode_q, mode_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    mode_d = mode_q;
    if (wr_en && (paddr[2] == bmp24_pkg::REG_PIXEL_MODE)) begin
      mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bmp24_pkg::MODE_COLOUR;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = (paddr[2] == bmp24_pkg::REG_PIXEL_MODE) ? {30'd0, mode_q} : 32'd0;
  assign pixel_mode_o = mode_q;

endmodule

// ----- hw/rtl/bmp24_in_stage.sv -----
// Input register of the BMP decoder: captures one byte word per cycle while it is empty or the held byte moves on.
// Depends on bmp24_pkg and bmp24_byte_if.
module bmp24_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bmp24_byte_if.sink             byte_i,
  input  logic                   adv_i,
  output logic                   vld_o,
  output bmp24_pkg::byte_item_t  item_o
);

  logic                  vld_q, vld_d;
  bmp24_pkg::byte_item_t item_q;
  logic                  take;

  // Refill in the same cycle the held byte moves on
  assign byte_i.ready = !vld_q || adv_i;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.file_byte     <= byte_i.file_byte;
      item_q.start_of_file <= byte_i.start_of_file;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- hw/rtl/bmp24_parser.sv -----
// Header parser, pixel assembler and result register of the BMP decoder.
// Depends on bmp24_pkg and bmp24_pix_if.
module bmp24_parser #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  bmp24_pkg::byte_item_t item_i,
  input  logic [1:0]            pixel_mode_i,
  output logic                  adv_o,
  bmp24_pix_if.source           pix_o
);

  localparam int DimW = $clog2(MAX_DIMENSION + 2);
  localparam int CntW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int IdxW = bmp24_pkg::IDX_W;
  localparam logic [31:0]     MaxDim32 = 32'(MAX_DIMENSION);
  localparam logic [DimW-1:0] DimMax   = DimW'(MAX_DIMENSION);
  localparam logic [DimW-1:0] DimSat   = DimW'(MAX_DIMENSION + 1);

  function automatic logic [DimW-1:0] clamp_dim(input logic [31:0] v);
    return (v > MaxDim32) ? DimSat : v[DimW-1:0];
  endfunction

  // Parse state
  logic [31:0]       pos_q, pos_d, pos_c;
  logic [31:0]       ha_q, ha_d, ha_c;
  logic [31:0]       off_q, off_d, off_c;
  logic [DimW-1:0]   w_q, w_d, w_c;
  logic [DimW-1:0]   h_q, h_d, h_c;
  logic [15:0]       depth_q, depth_d, depth_c;
  logic [CntW-1:0]   col_q, col_d, col_c;
  logic [CntW-1:0]   row_q, row_d, row_c;
  logic [IdxW-1:0]   base_q, base_d, base_c;
  bmp24_pkg::phase_e phase_q, phase_d, phase_c;
  logic [1:0]        rbp_q, rbp_d, rbp_c;
  logic [7:0]        hb_q, hb_d, hb_c;
  logic [7:0]        hg_q, hg_d, hg_c;
  logic              halt_q, halt_d, halt_c;

  // Result register
  logic              out_vld_q, out_vld_d;
  logic [1:0]        st_q, st_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        r_q, g_q, b_q, lvl_q, lvl_d;
  logic              last_q, last_d;
  logic              res_vld;

  logic [7:0]        byte_c;
  logic              sof;
  logic [9:0]        sum;
  logic [7:0]        mean;
  logic [2*DimW-1:0] prod;
  logic [1:0]        pad;
  logic [1:0]        rbp_n;
  logic              row_end;
  logic              last_c;

  assign adv_o  = in_vld_i && (!out_vld_q || pix_o.ready);
  assign byte_c = item_i.file_byte;
  assign sof    = item_i.start_of_file;

  // A start byte clears the parse state before it is itself parsed
  assign pos_c   = sof ? '0 : pos_q;
  assign ha_c    = sof ? '0 : ha_q;
  assign off_c   = sof ? '0 : off_q;
  assign w_c     = sof ? '0 : w_q;
  assign h_c     = sof ? '0 : h_q;
  assign depth_c = sof ? '0 : depth_q;
  assign col_c   = sof ? '0 : col_q;
  assign row_c   = sof ? '0 : row_q;
  assign base_c  = sof ? '0 : base_q;
  assign phase_c = sof ? bmp24_pkg::PH_BLUE : phase_q;
  assign rbp_c   = sof ? '0 : rbp_q;
  assign hb_c    = sof ? '0 : hb_q;
  assign hg_c    = sof ? '0 : hg_q;
  assign halt_c  = sof ? 1'b0 : halt_q;

  assign sum  = {2'd0, byte_c} + {2'd0, hg_c} + {2'd0, hb_c};
  assign mean = bmp24_pkg::div3(sum);
  assign prod = {{DimW{1'b0}}, h_c - DimW'(1)} * {{DimW{1'b0}}, w_c};
  assign pad  = w_c[1:0];
  assign rbp_n   = rbp_c + 2'd1;
  assign row_end = (DimW'(col_c) + DimW'(1)) >= w_c;
  assign last_c  = row_end && ((DimW'(row_c) + DimW'(1)) >= h_c);

  always_comb begin
    pos_d   = pos_c;
    ha_d    = ha_c;
    off_d   = off_c;
    w_d     = w_c;
    h_d     = h_c;
    depth_d = depth_c;
    col_d   = col_c;
    row_d   = row_c;
    base_d  = base_c;
    phase_d = phase_c;
    rbp_d   = rbp_c;
    hb_d    = hb_c;
    hg_d    = hg_c;
    halt_d  = halt_c;
    res_vld = 1'b0;
    st_d    = bmp24_pkg::STATUS_PIXEL;
    idx_d   = '0;
    lvl_d   = '0;
    last_d  = 1'b0;

    unique case (pixel_mode_i)
      bmp24_pkg::MODE_GREY: lvl_d = mean;
      bmp24_pkg::MODE_BW:   lvl_d = {7'd0, mean > bmp24_pkg::BW_THRESHOLD};
      default:              lvl_d = '0;
    endcase

    if (!halt_c) begin
      if (pos_c < bmp24_pkg::POS_DATA_MIN) begin
        ha_d  = {byte_c, ha_c[31:8]};
        pos_d = pos_c + 32'd1;
        if (pos_c == bmp24_pkg::POS_OFFSET_END) begin
          off_d = ha_d;
        end else if (pos_c == bmp24_pkg::POS_WIDTH_END) begin
          w_d = clamp_dim(ha_d);
        end else if (pos_c == bmp24_pkg::POS_HEIGHT_END) begin
          h_d = clamp_dim(ha_d);
        end else if (pos_c == bmp24_pkg::POS_DEPTH_END) begin
          depth_d = ha_d[31:16];
        end else if (pos_c == bmp24_pkg::POS_HEADER_END) begin
          if (depth_c != bmp24_pkg::DEPTH_24) begin
            halt_d  = 1'b1;
            res_vld = 1'b1;
            st_d    = bmp24_pkg::STATUS_BAD_DEPTH;
          end else if (w_c == '0 || w_c > DimMax || h_c == '0 || h_c > DimMax) begin
            halt_d  = 1'b1;
            res_vld = 1'b1;
            st_d    = bmp24_pkg::STATUS_BAD_SIZE;
          end else begin
            if (off_c < bmp24_pkg::POS_DATA_MIN) begin
              off_d = bmp24_pkg::POS_DATA_MIN;
            end
            col_d   = '0;
            row_d   = '0;
            phase_d = bmp24_pkg::PH_BLUE;
            rbp_d   = '0;
            base_d  = IdxW'(prod);
          end
        end
      end else if (pos_c < off_c) begin
        pos_d = pos_c + 32'd1;
      end else begin
        unique case (phase_c)
          bmp24_pkg::PH_PAD: begin
            if (rbp_n >= pad) begin
              phase_d = bmp24_pkg::PH_BLUE;
              rbp_d   = '0;
            end else begin
              rbp_d = rbp_n;
            end
          end
          bmp24_pkg::PH_BLUE: begin
            hb_d    = byte_c;
            phase_d = bmp24_pkg::PH_GREEN;
          end
          bmp24_pkg::PH_GREEN: begin
            hg_d    = byte_c;
            phase_d = bmp24_pkg::PH_RED;
          end
          bmp24_pkg::PH_RED: begin
            res_vld = 1'b1;
            idx_d   = base_c + IdxW'(col_c);
            last_d  = last_c;
            phase_d = bmp24_pkg::PH_BLUE;
            if (last_c) begin
              halt_d = 1'b1;
            end else if (row_end) begin
              col_d  = '0;
              row_d  = row_c + CntW'(1);
              base_d = base_c - IdxW'(w_c);
              if (pad != 2'd0) begin
                phase_d = bmp24_pkg::PH_PAD;
                rbp_d   = '0;
              end
            end else begin
              col_d = col_c + CntW'(1);
            end
          end
          default: phase_d = bmp24_pkg::PH_BLUE;
        endcase
      end
    end

    if (st_d != bmp24_pkg::STATUS_PIXEL) begin
      lvl_d = '0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv_o) begin
      out_vld_d = res_vld;
    end else if (pix_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ha_q      <= '0;
      off_q     <= '0;
      w_q       <= '0;
      h_q       <= '0;
      depth_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      base_q    <= '0;
      phase_q   <= bmp24_pkg::PH_BLUE;
      rbp_q     <= '0;
      hb_q      <= '0;
      hg_q      <= '0;
      halt_q    <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (adv_o) begin
        pos_q   <= pos_d;
        ha_q    <= ha_d;
        off_q   <= off_d;
        w_q     <= w_d;
        h_q     <= h_d;
        depth_q <= depth_d;
        col_q   <= col_d;
        row_q   <= row_d;
        base_q  <= base_d;
        phase_q <= phase_d;
        rbp_q   <= rbp_d;
        hb_q    <= hb_d;
        hg_q    <= hg_d;
        halt_q  <= halt_d;
      end
    end
  end

  // Error words carry zero colour
  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld) begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      r_q    <= (st_d == bmp24_pkg::STATUS_PIXEL) ? byte_c : 8'd0;
      g_q    <= (st_d == bmp24_pkg::STATUS_PIXEL) ? hg_c : 8'd0;
      b_q    <= (st_d == bmp24_pkg::STATUS_PIXEL) ? hb_c : 8'd0;
      lvl_q  <= lvl_d;
      last_q <= last_d;
    end
  end

  assign pix_o.valid       = out_vld_q;
  assign pix_o.status      = st_q;
  assign pix_o.pixel_index = idx_q;
  assign pix_o.red         = r_q;
  assign pix_o.green       = g_q;
  assign pix_o.blue        = b_q;
  assign pix_o.level       = lvl_q;
  assign pix_o.last_pixel  = last_q;

endmodule

// ----- hw/rtl/bmp24_pixel_stream_decoder.sv -----
// 24-bit BMP pixel stream decoder, top level.
// Ready follows the result register, which holds each result word for the output.
// Throughput: one byte per cycle unless the output stalls; zero or one result word per
// byte; the input register and the result register are the only stages.
// Reset: pixel_mode is colour and the parser ignores bytes until a start_of_file byte.
// Depends on bmp24_pkg, bmp24_byte_if, bmp24_pix_if and the bmp24_* submodules.
module bmp24_pixel_stream_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmp24_byte_if.sink  byte_i,
  bmp24_pix_if.source pix_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  in_vld;
  logic                  adv;
  bmp24_pkg::byte_item_t item;
  logic [1:0]            pixel_mode;

  bmp24_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_mode_o (pixel_mode)
  );

  bmp24_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .adv_i  (adv),
    .vld_o  (in_vld),
    .item_o (item)
  );

  bmp24_parser #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (in_vld),
    .item_i       (item),
    .pixel_mode_i (pixel_mode),
    .adv_o        (adv),
    .pix_o        (pix_o)
  );

endmodule
